/* hdl/rfss_pkg.sv */
`timescale 1ns / 1ps

package rfss_pkg;

    // Field widths
    localparam int FREQ_W     = 48;
    localparam int STEP_W     = 27;
    localparam int QSTEP_W    = 25;
    localparam int DWELL_W    = 10;
    localparam int PTR_W      = 4;
    localparam int SLOT_W     = 3;
    localparam int CMD_W      = 2;
    localparam int MHZ_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 27;

    // Defaults for top level parameters
    localparam int MAX_RANGES_DEF  = 10;
    localparam int HZ_PER_UNIT_DEF = 1000000;

    // Rotating buffer depth
    localparam int BUFFER_SLOTS = 2;

    // Commands
    localparam logic [CMD_W-1:0] CMD_BLOCK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_HZ     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERLEAVED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TUNE_OFFSET = 3'd4;

    // Configuration reset values
    localparam logic [STEP_W-1:0]  STEP_RST   = 27'd20000000;
    localparam logic [QSTEP_W-1:0] QSTEP_RST  = 25'd5000000;
    localparam logic [STEP_W-1:0]  TQSTEP_RST = 27'd15000000;
    localparam logic [DWELL_W-1:0] DWELL_RST  = 10'd1;
    localparam logic [PTR_W-1:0]   RCOUNT_RST = 4'd1;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [3:0]       entry_index;
        logic [MHZ_W-1:0] range_start_mhz;
        logic [MHZ_W-1:0] range_end_mhz;
    } t_in;

    typedef struct packed {
        logic [SLOT_W-1:0] buffer_slot;
        logic [FREQ_W-1:0] header_freq_hz;
        logic              retune;
        logic [FREQ_W-1:0] tune_freq_hz;
    } t_out;

    // Command after scaling the range edges to hertz
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [3:0]        idx;
        logic [FREQ_W-1:0] start_hz;
        logic [FREQ_W-1:0] end_hz;
    } t_item;

    typedef struct packed {
        logic [FREQ_W-1:0] start_hz;
        logic [FREQ_W-1:0] end_hz;
    } t_range;

    typedef struct packed {
        logic [STEP_W-1:0]  step;
        logic [QSTEP_W-1:0] q_step;
        logic [STEP_W-1:0]  tq_step;
        logic [DWELL_W-1:0] dwell;
        logic [PTR_W-1:0]   rcount;
        logic               interleaved;
    } t_cfg;

    // Result before the tune offset is applied
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [FREQ_W-1:0] header;
        logic              retune;
        logic [FREQ_W-1:0] new_freq;
    } t_res;

endpackage

/* hdl/rfss_range_mem.sv */
`timescale 1ns / 1ps

module rfss_range_mem
    import rfss_pkg::*;
#(
    parameter int MAX_RANGES = MAX_RANGES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [PTR_W-1:0]            i_waddr,
    input  t_range                      i_wdata,
    input  logic [PTR_W-1:0]            i_raddr_end,
    input  logic [PTR_W-1:0]            i_raddr_start,
    output logic [FREQ_W-1:0]           o_end_hz,
    output logic [FREQ_W-1:0]           o_start_hz
);

    localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

    t_range            r_mem [MAX_RANGES];
    logic [FREQ_W-1:0] r_end_hz;
    logic [FREQ_W-1:0] r_start_hz;

    logic w_end_ok;
    logic w_start_ok;

    // Entries beyond the table read as zero
    assign w_end_ok   = {1'b0, i_raddr_end} < (PTR_W + 1)'(MAX_RANGES);
    assign w_start_ok = {1'b0, i_raddr_start} < (PTR_W + 1)'(MAX_RANGES);

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr[AW-1:0]] <= i_wdata;
        end
    end

    // Registered reads with write-through on a same-cycle write
    always_ff @(posedge i_clk) begin
        if (!w_end_ok) begin
            r_end_hz <= '0;
        end else if (i_we && i_waddr == i_raddr_end) begin
            r_end_hz <= i_wdata.end_hz;
        end else begin
            r_end_hz <= r_mem[i_raddr_end[AW-1:0]].end_hz;
        end

        if (!w_start_ok) begin
            r_start_hz <= '0;
        end else if (i_we && i_waddr == i_raddr_start) begin
            r_start_hz <= i_wdata.start_hz;
        end else begin
            r_start_hz <= r_mem[i_raddr_start[AW-1:0]].start_hz;
        end
    end

    assign o_end_hz   = r_end_hz;
    assign o_start_hz = r_start_hz;

endmodule

/* hdl/rfss_step_core.sv */
`timescale 1ns / 1ps

module rfss_step_core
    import rfss_pkg::*;
#(
    parameter int MAX_RANGES = MAX_RANGES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_adv,
    input  t_item i_item,
    input  t_cfg  i_cfg,
    input  logic  i_ld,
    output logic  o_res_valid,
    output t_res  o_res
);

    function automatic logic [PTR_W-1:0] next_of(input logic [PTR_W-1:0] ptr,
                                                 input logic [PTR_W-1:0] count);
        logic [PTR_W-1:0] nxt;
        nxt = ptr + 1'b1;
        return (nxt >= count) ? '0 : nxt;
    endfunction

    logic [FREQ_W-1:0]  r_freq, n_freq;
    logic [PTR_W-1:0]   r_ptr, n_ptr;
    logic               r_odd, n_odd;
    logic [DWELL_W-1:0] r_blk, n_blk;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [FREQ_W-1:0]  r_start0;
    logic               r_res_valid;
    t_res               r_res;

    logic               w_we;
    logic [PTR_W-1:0]   w_raddr_start;
    logic [FREQ_W-1:0]  w_end_hz;
    logic [FREQ_W-1:0]  w_start_next;
    logic [PTR_W-1:0]   w_nxt1, w_nxt2, w_nx0;
    logic [FREQ_W-1:0]  w_probe;
    logic               w_at_edge;
    logic [DWELL_W-1:0] w_blk1;
    logic               w_hit;
    logic [SLOT_W-1:0]  w_slot1;
    logic               w_idx_ok;
    t_res               w_res;
    t_range             w_wdata;

    rfss_range_mem #(
        .MAX_RANGES (MAX_RANGES)
    ) u_mem (
        .i_clk         (i_clk),
        .i_we          (w_we),
        .i_waddr       (i_item.idx),
        .i_wdata       (w_wdata),
        .i_raddr_end   (n_ptr),
        .i_raddr_start (w_raddr_start),
        .o_end_hz      (w_end_hz),
        .o_start_hz    (w_start_next)
    );

    assign w_wdata.start_hz = i_item.start_hz;
    assign w_wdata.end_hz   = i_item.end_hz;

    assign w_idx_ok  = {1'b0, i_item.idx} < (PTR_W + 1)'(MAX_RANGES);
    assign w_nxt1    = next_of(r_ptr, i_cfg.rcount);
    assign w_nxt2    = next_of(w_nxt1, i_cfg.rcount);
    assign w_nx0     = next_of('0, i_cfg.rcount);
    assign w_probe   = r_freq + FREQ_W'(i_cfg.step);
    assign w_at_edge = w_probe >= w_end_hz;
    assign w_blk1    = r_blk + 1'b1;
    assign w_hit     = w_blk1 == i_cfg.dwell;
    assign w_slot1   = r_slot + 1'b1;

    always_comb begin
        n_freq = r_freq;
        n_ptr  = r_ptr;
        n_odd  = r_odd;
        n_blk  = r_blk;
        n_slot = r_slot;
        w_we   = 1'b0;
        if (i_adv) begin
            case (i_item.cmd)
                CMD_WRITE: begin
                    w_we = w_idx_ok;
                end
                CMD_RESTART: begin
                    n_ptr  = '0;
                    n_freq = r_start0;
                    n_odd  = 1'b1;
                    n_blk  = '0;
                    n_slot = '0;
                end
                CMD_BLOCK: begin
                    n_slot = ({1'b0, w_slot1} >= (SLOT_W + 1)'(BUFFER_SLOTS)) ? '0 : w_slot1;
                    n_blk  = w_hit ? '0 : w_blk1;
                    if (w_hit) begin
                        if (i_cfg.interleaved) begin
                            if (!r_odd && w_at_edge) begin
                                n_ptr  = w_nxt1;
                                n_freq = w_start_next;
                            end else if (r_odd) begin
                                n_freq = r_freq + FREQ_W'(i_cfg.q_step);
                            end else begin
                                n_freq = r_freq + FREQ_W'(i_cfg.tq_step);
                            end
                            n_odd = ~r_odd;
                        end else if (w_at_edge) begin
                            n_ptr  = w_nxt1;
                            n_freq = w_start_next;
                        end else begin
                            n_freq = w_probe;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Read the start edge of the range after the one that becomes current
    always_comb begin
        if (n_ptr == r_ptr) begin
            w_raddr_start = w_nxt1;
        end else if (n_ptr == w_nxt1) begin
            w_raddr_start = w_nxt2;
        end else begin
            w_raddr_start = w_nx0;
        end
    end

    always_comb begin
        w_res.slot     = r_slot;
        w_res.header   = r_freq;
        w_res.retune   = w_hit;
        w_res.new_freq = n_freq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq <= '0;
            r_ptr  <= '0;
            r_odd  <= 1'b1;
            r_blk  <= '0;
            r_slot <= '0;
        end else begin
            r_freq <= n_freq;
            r_ptr  <= n_ptr;
            r_odd  <= n_odd;
            r_blk  <= n_blk;
            r_slot <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we && i_item.idx == '0) begin
            r_start0 <= i_item.start_hz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (i_ld) begin
            r_res_valid <= i_adv && i_item.cmd == CMD_BLOCK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_res <= w_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

`ifndef SYNTHESIS
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_item.cmd == CMD_RESTART)
        |=> (r_freq == r_start0 && r_blk == '0 && r_odd && r_ptr == '0))
        else $error("restart did not reload sweep state");

    a_dwell_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_item.cmd == CMD_BLOCK && w_hit) |=> (r_blk == '0))
        else $error("block counter not cleared at end of dwell");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_slot} < (SLOT_W + 1)'(BUFFER_SLOTS)))
        else $error("buffer slot out of range");
`endif

endmodule

/* hdl/rf_frequency_sweep_sequencer.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// input     in         i_valid / o_stall     i_in  (t_in: cmd, entry, range edges)
// result    out        o_valid / i_stall     o_out (t_out: slot, header, retune, tune)
// config    in         i_cfg_we              i_cfg_idx, i_cfg_data
//
// One transfer per cycle while the result channel is not stalled; a block command reaches o_out
// through the stages behind the input register (edge scaling, sweep step, offset add).
// The sweep step loop (48-bit add and compare against the current range end) sets the rate.
// Synchronous active-low reset clears pipeline valids, sweep state and configuration;
// the range table has no reset and no clearing pass.
// Stalls collapse bubbles: input transfers continue while a result waits, until full.

module rf_frequency_sweep_sequencer
    import rfss_pkg::*;
#(
    parameter int MAX_RANGES  = MAX_RANGES_DEF,
    parameter int HZ_PER_UNIT = HZ_PER_UNIT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in                   i_in,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out                  o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int HZ_W   = $clog2(HZ_PER_UNIT + 1);
    localparam int PROD_W = MHZ_W + HZ_W;

    // Configuration
    t_cfg              r_cfg;
    logic [STEP_W-1:0] r_offset;

    // Pipeline registers
    logic  r_v1, r_v2, r_v4;
    t_in   r_s1;
    t_item r_s2;
    t_out  r_s4;

    logic              w_ld1, w_ld2, w_ld3, w_ld4, w_adv2;
    logic              w_res_valid;
    t_res              w_res;
    logic [PROD_W-1:0] w_start_prod, w_end_prod;

    // Advance a stage when the next one is empty or moving; non-block commands
    // finish in the step stage and never need the result register.
    assign w_ld4  = !r_v4 || !i_stall;
    assign w_ld3  = !w_res_valid || w_ld4;
    assign w_adv2 = r_v2 && (r_s2.cmd != CMD_BLOCK || w_ld3);
    assign w_ld2  = !r_v2 || w_adv2;
    assign w_ld1  = !r_v1 || w_ld2;

    assign o_stall = !w_ld1;
    assign o_valid = r_v4;
    assign o_out   = r_s4;

    // Configuration writes; precompute the quarter and three-quarter steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step        <= STEP_RST;
            r_cfg.q_step      <= QSTEP_RST;
            r_cfg.tq_step     <= TQSTEP_RST;
            r_cfg.dwell       <= DWELL_RST;
            r_cfg.rcount      <= RCOUNT_RST;
            r_cfg.interleaved <= 1'b0;
            r_offset          <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STEP_HZ: begin
                    r_cfg.step    <= i_cfg_data[STEP_W-1:0];
                    r_cfg.q_step  <= i_cfg_data[STEP_W-1:2];
                    r_cfg.tq_step <= STEP_W'(((STEP_W + 2)'(i_cfg_data)
                                     + ((STEP_W + 2)'(i_cfg_data) << 1)) >> 2);
                end
                CFG_DWELL_COUNT: r_cfg.dwell       <= i_cfg_data[DWELL_W-1:0];
                CFG_RANGE_COUNT: r_cfg.rcount      <= i_cfg_data[PTR_W-1:0];
                CFG_INTERLEAVED: r_cfg.interleaved <= i_cfg_data[0];
                CFG_TUNE_OFFSET: r_offset          <= i_cfg_data[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_ld1) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld1) begin
            r_s1 <= i_in;
        end
    end

    // Scale the range edges to hertz
    assign w_start_prod = PROD_W'(r_s1.range_start_mhz) * PROD_W'(HZ_PER_UNIT);
    assign w_end_prod   = PROD_W'(r_s1.range_end_mhz) * PROD_W'(HZ_PER_UNIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_ld2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld2) begin
            r_s2.cmd      <= r_s1.cmd;
            r_s2.idx      <= r_s1.entry_index;
            r_s2.start_hz <= FREQ_W'(w_start_prod);
            r_s2.end_hz   <= FREQ_W'(w_end_prod);
        end
    end

    // Sweep step and result register
    rfss_step_core #(
        .MAX_RANGES (MAX_RANGES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv2),
        .i_item      (r_s2),
        .i_cfg       (r_cfg),
        .i_ld        (w_ld3),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // Output register: add the tune offset on retune
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_ld4) begin
            r_v4 <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld4) begin
            r_s4.buffer_slot    <= w_res.slot;
            r_s4.header_freq_hz <= w_res.header;
            r_s4.retune         <= w_res.retune;
            r_s4.tune_freq_hz   <= w_res.retune ? (w_res.new_freq + FREQ_W'(r_offset))
                                                : '0;
        end
    end

`ifndef SYNTHESIS
    a_tune_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out.retune) |-> (o_out.tune_freq_hz == '0))
        else $error("tune frequency set without retune");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && !w_ld3) |=> w_res_valid)
        else $error("result lost while output stalled");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out)))
        else $error("stalled result changed");
`endif

endmodule
